// File: hdl/hgbhf_pkg.sv
`default_nettype none
package hgbhf_pkg;

    localparam int COORD_W = 32;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 16;
    localparam int ACC_W   = 64;
    localparam int NCNT_W  = 16;

    // command codes
    typedef enum logic [0:0] {
        CMD_ADD   = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // answer status codes
    localparam logic [1:0] ST_OBSERVED = 2'd0;
    localparam logic [1:0] ST_RING     = 2'd1;
    localparam logic [1:0] ST_NODATA   = 2'd2;

    localparam logic [4:0] CELL_SHIFT_RST = 5'd17;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // register address
    localparam logic [0:0] ADDR_CELL_SHIFT = 1'b0;

    // classified item passed from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [31:0] height;
    } job_t;

    // divider request
    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  dividend;
        logic [NCNT_W-1:0] divisor;
    } div_req_t;

    // back-end state machine
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_READ,
        BK_WAIT,
        BK_ADD,
        BK_OBS_DIV,
        BK_OBS_WAIT,
        BK_RING_STEP,
        BK_RING_READ,
        BK_RING_CHECK,
        BK_RING_DIV,
        BK_RING_DWAIT,
        BK_RING_ADD,
        BK_RING_END,
        BK_FINAL_DIV,
        BK_FINAL_WAIT,
        BK_OUT
    } bk_state_t;

endpackage
`default_nettype wire

// File: hdl/hgbhf_front.sv
`default_nettype none
module hgbhf_front #(
    parameter int GRID_DIM = 256
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire [4:0]           cell_shift,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire                 in_cmd,
    input  wire [31:0]          in_pos_x,
    input  wire [31:0]          in_pos_z,
    input  wire [31:0]          in_height,
    input  wire [7:0]           in_query_row,
    input  wire [7:0]           in_query_col,
    output logic                q_valid,
    input  wire                 q_ready,
    output hgbhf_pkg::job_t     q_job
);
    import hgbhf_pkg::*;

    localparam logic [9:0] MAX_IDX = 10'(GRID_DIM - 1);

    logic [1:0] cnt_reg, cnt_next;
    job_t       fifo_reg [2];
    logic       wp_reg, rp_reg;
    logic       push, pop;
    job_t       job_in;
    logic [31:0] sx, sz;
    logic [9:0] bx, bz, qr, qc;

    // arithmetic shift floors toward minus infinity, then clamp
    function automatic logic [9:0] bin_idx(input logic [31:0] v, input logic [4:0] s);
        logic [31:0] q;
        q = 32'($signed(v) >>> s);
        if (q[31])
            return 10'd0;
        else if (q > 32'(MAX_IDX))
            return MAX_IDX;
        else
            return q[9:0];
    endfunction

    always_comb
    begin
        sx = in_pos_x;
        sz = in_pos_z;
        bx = bin_idx(sx, cell_shift);
        bz = bin_idx(sz, cell_shift);
        qr = ({2'b0, in_query_row} > MAX_IDX) ? MAX_IDX : {2'b0, in_query_row};
        qc = ({2'b0, in_query_col} > MAX_IDX) ? MAX_IDX : {2'b0, in_query_col};
        job_in.cmd    = cmd_t'(in_cmd);
        job_in.row    = (in_cmd == CMD_QUERY) ? qr : bx;
        job_in.col    = (in_cmd == CMD_QUERY) ? qc : bz;
        job_in.height = in_height;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_job    = fifo_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // two-entry queue
    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wp_reg] <= job_in;
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) (cnt_reg == 2'd2) |-> !push;
    endproperty
    assert property (p_no_overflow) else $error("queue overflow");

    property p_cnt_range;
        @(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3;
    endproperty
    assert property (p_cnt_range) else $error("queue count out of range");

    property p_pop_track;
        @(posedge clk) disable iff (!rst_n) (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1);
    endproperty
    assert property (p_pop_track) else $error("queue count not decremented");

endmodule
`default_nettype wire

// File: hdl/hgbhf_div.sv
`default_nettype none
module hgbhf_div (
    input  wire                      clk,
    input  wire                      rst_n,
    input  hgbhf_pkg::div_req_t      req,
    output logic                     done,
    output logic [hgbhf_pkg::ACC_W-1:0] quot
);
    import hgbhf_pkg::*;

    logic [ACC_W-1:0]  rem_reg, q_reg;
    logic [NCNT_W-1:0] dv_reg;
    logic              neg_reg, busy_reg, done_reg;
    logic [6:0]        step_reg;
    logic [ACC_W:0]    trial;
    logic [ACC_W-1:0]  shifted;
    logic [ACC_W-1:0]  mag;

    // restoring division, one quotient bit per cycle, sign applied at end
    always_comb
    begin
        mag     = req.dividend[ACC_W-1] ? (~req.dividend + 1'b1) : req.dividend;
        shifted = {rem_reg[ACC_W-2:0], q_reg[ACC_W-1]};
        trial   = {1'b0, shifted} - {{(ACC_W+1-NCNT_W){1'b0}}, dv_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 7'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 7'd1;
                if (step_reg == 7'(ACC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            q_reg   <= mag;
            dv_reg  <= req.divisor;
            neg_reg <= req.dividend[ACC_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[ACC_W])
            begin
                rem_reg <= trial[ACC_W-1:0];
                q_reg   <= {q_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[ACC_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (~q_reg + 1'b1) : q_reg;

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg);
    endproperty
    assert property (p_done_after_busy) else $error("done without busy");

    property p_nonzero_div;
        @(posedge clk) disable iff (!rst_n) req.start |-> (req.divisor != '0);
    endproperty
    assert property (p_nonzero_div) else $error("divide by zero");

    property p_no_restart;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> !req.start;
    endproperty
    assert property (p_no_restart) else $error("divider restarted while busy");

endmodule
`default_nettype wire

// File: hdl/hgbhf_back.sv
`default_nettype none
module hgbhf_back #(
    parameter int GRID_DIM = 256,
    parameter int IDX_W    = 8
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              q_valid,
    output logic             q_ready,
    input  hgbhf_pkg::job_t  q_job,
    output logic             out_valid,
    input  wire              out_ready,
    output logic [31:0]      out_cell_height,
    output logic [1:0]       out_status,
    output logic [7:0]       out_ring_distance,
    output logic             clearing
);
    import hgbhf_pkg::*;

    localparam int ADDR_W = 2 * IDX_W;
    localparam int CELLS  = 1 << ADDR_W;
    localparam int D_W    = 11;

    bk_state_t st_reg, st_next;

    // cell store: sum and count side by side
    logic [SUM_W+CNT_W-1:0] mem [CELLS];
    logic [SUM_W+CNT_W-1:0] rd_reg;
    logic [ADDR_W-1:0]      raddr, waddr;
    logic                   we;
    logic [SUM_W+CNT_W-1:0] wdata;

    logic [ADDR_W:0]  clr_reg;
    job_t             job_reg;
    logic signed [D_W:0] d_reg, row_s, col_s, d_next;
    logic [D_W+2:0]   t_reg, t_next;
    logic signed [D_W+1:0] vr, vc;
    logic             vin;
    logic signed [ACC_W-1:0] acc_reg;
    logic [NCNT_W-1:0] n_reg;
    logic [31:0]      hgt_reg;
    logic [1:0]       sts_reg;
    logic [7:0]       dist_reg;
    logic             ovalid_reg;
    div_req_t         dreq;
    logic             ddone;
    logic [ACC_W-1:0] dquot;
    logic [D_W+2:0]   per_ring;
    logic [SUM_W-1:0] rsum;
    logic [CNT_W-1:0] rcnt;

    assign rsum = rd_reg[SUM_W+CNT_W-1:CNT_W];
    assign rcnt = rd_reg[CNT_W-1:0];
    assign clearing = !clr_reg[ADDR_W];
    assign row_s = $signed({2'b0, job_reg.row});
    assign col_s = $signed({2'b0, job_reg.col});

    hgbhf_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .done (ddone),
        .quot (dquot)
    );

    // ring walk: t runs over 8*d positions; left/right columns then top/bottom rows
    always_comb
    begin
        per_ring = (D_W+3)'(d_reg) << 3;
        vr = '0;
        vc = '0;
        if (t_reg < (D_W+3)'(d_reg) * 4 + 2)
        begin
            vr = (D_W+2)'(row_s - d_reg + $signed({1'b0, t_reg[D_W+2:1]}));
            vc = (D_W+2)'(t_reg[0] ? col_s + d_reg : col_s - d_reg);
        end
        else
        begin
            vc = (D_W+2)'(col_s - d_reg + 1
                 + $signed({1'b0, (t_reg - ((D_W+3)'(d_reg) * 4 + 2)) >> 1}));
            vr = (D_W+2)'(t_reg[0] ? row_s - d_reg : row_s + d_reg);
        end
        vin = (vr >= 0) && (vr < GRID_DIM) && (vc >= 0) && (vc < GRID_DIM);
    end

    // state machine
    always_comb
    begin
        st_next  = st_reg;
        q_ready  = 1'b0;
        raddr    = {job_reg.row[IDX_W-1:0], job_reg.col[IDX_W-1:0]};
        we       = 1'b0;
        waddr    = raddr;
        wdata    = '0;
        dreq     = '0;
        t_next   = t_reg;
        d_next   = d_reg;
        if (!clr_reg[ADDR_W])
        begin
            we    = 1'b1;
            waddr = clr_reg[ADDR_W-1:0];
        end
        unique case (st_reg)
            BK_IDLE:
            begin
                q_ready = clr_reg[ADDR_W];
                if (q_valid && q_ready)
                    st_next = BK_READ;
            end
            BK_READ:      st_next = BK_WAIT;
            BK_WAIT:
                st_next = (job_reg.cmd == CMD_ADD) ? BK_ADD : BK_OBS_DIV;
            BK_ADD:
            begin
                if (rcnt != COUNT_MAX)
                begin
                    we    = 1'b1;
                    wdata = {rsum + {{(SUM_W-32){job_reg.height[31]}}, job_reg.height},
                             rcnt + 1'b1};
                end
                st_next = BK_IDLE;
            end
            BK_OBS_DIV:
            begin
                if (rcnt != '0)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = ACC_W'($signed(rsum));
                    dreq.divisor  = rcnt;
                    st_next = BK_OBS_WAIT;
                end
                else
                begin
                    d_next  = (D_W+1)'(1);
                    t_next  = '0;
                    st_next = BK_RING_STEP;
                end
            end
            BK_OBS_WAIT:  if (ddone) st_next = BK_OUT;
            BK_RING_STEP:
            begin
                if (t_reg == per_ring)
                    st_next = BK_RING_END;
                else if (vin)
                begin
                    raddr   = {vr[IDX_W-1:0], vc[IDX_W-1:0]};
                    st_next = BK_RING_READ;
                end
                else
                    t_next = t_reg + 1'b1;
            end
            BK_RING_READ:
            begin
                // hold the ring cell address so the read data stays put
                raddr   = {vr[IDX_W-1:0], vc[IDX_W-1:0]};
                st_next = BK_RING_CHECK;
            end
            BK_RING_CHECK:
            begin
                if (rcnt != '0)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = ACC_W'($signed(rsum));
                    dreq.divisor  = rcnt;
                    st_next = BK_RING_DWAIT;
                end
                else
                begin
                    t_next  = t_reg + 1'b1;
                    st_next = BK_RING_STEP;
                end
            end
            BK_RING_DIV:  st_next = BK_RING_DWAIT;
            BK_RING_DWAIT: if (ddone) st_next = BK_RING_ADD;
            BK_RING_ADD:
            begin
                t_next  = t_reg + 1'b1;
                st_next = BK_RING_STEP;
            end
            BK_RING_END:
            begin
                if (n_reg != '0)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = acc_reg;
                    dreq.divisor  = n_reg;
                    st_next = BK_FINAL_WAIT;
                end
                else if (d_reg == GRID_DIM - 1)
                    st_next = BK_OUT;
                else
                begin
                    d_next  = (D_W+1)'(d_reg + 1);
                    t_next  = '0;
                    st_next = BK_RING_STEP;
                end
            end
            BK_FINAL_DIV:  st_next = BK_FINAL_WAIT;
            BK_FINAL_WAIT: if (ddone) st_next = BK_OUT;
            BK_OUT:
                if (!ovalid_reg || out_ready)
                    st_next = BK_IDLE;
            default:      st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= BK_IDLE;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (!clr_reg[ADDR_W])
                clr_reg <= clr_reg + 1'b1;
            if (st_reg == BK_OUT && st_next == BK_IDLE)
                ovalid_reg <= 1'b1;
            else if (out_valid && out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // store access
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        if (st_reg == BK_IDLE && q_valid && q_ready)
            job_reg <= q_job;
        d_reg <= d_next;
        t_reg <= t_next;
        if (st_reg == BK_OBS_DIV || (st_reg == BK_RING_END && st_next == BK_RING_STEP))
        begin
            acc_reg <= '0;
            n_reg   <= '0;
        end
        if (st_reg == BK_RING_ADD)
        begin
            acc_reg <= acc_reg + $signed(dquot);
            n_reg   <= n_reg + 1'b1;
        end
        if (st_reg == BK_OBS_WAIT && ddone)
        begin
            hgt_reg  <= dquot[31:0];
            sts_reg  <= ST_OBSERVED;
            dist_reg <= 8'd0;
        end
        if (st_reg == BK_FINAL_WAIT && ddone)
        begin
            hgt_reg  <= dquot[31:0];
            sts_reg  <= ST_RING;
            dist_reg <= (d_reg > 255) ? 8'd255 : d_reg[7:0];
        end
        if (st_reg == BK_RING_END && n_reg == '0 && d_reg == GRID_DIM - 1)
        begin
            hgt_reg  <= '0;
            sts_reg  <= ST_NODATA;
            dist_reg <= 8'd0;
        end
        if (st_reg == BK_OUT && st_next == BK_IDLE)
        begin
            out_cell_height   <= hgt_reg;
            out_status        <= sts_reg;
            out_ring_distance <= dist_reg;
        end
    end

    assign out_valid = ovalid_reg;

    property p_no_take_while_clear;
        @(posedge clk) disable iff (!rst_n) clearing |-> !q_ready;
    endproperty
    assert property (p_no_take_while_clear) else $error("item taken during clear");

    property p_status_code;
        @(posedge clk) disable iff (!rst_n) out_valid |-> (out_status != 2'd3);
    endproperty
    assert property (p_status_code) else $error("bad status");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n) (out_valid && !out_ready) |=> $stable(out_cell_height);
    endproperty
    assert property (p_out_hold) else $error("output changed while stalled");

endmodule
`default_nettype wire

// File: hdl/height_grid_binning_hole_fill.sv
// add: take the beat, read, settle, write back into the cell store unless its count is saturated
// query on an observed cell: the one-bit-per-cycle divider gives the cell's sum over its count
// query on an empty cell: per ring d up to 8*d probes, each stepped, read and checked inside the grid,
//   only stepped outside, plus a divide per observed cell on the ring and one final divide
// reset sets cell_shift to 17 and sweeps all 2^(2*clog2(GRID_DIM)) cells of the cell store,
//   one cell a cycle; at most two input beats wait in the queue meanwhile
`default_nettype none
module height_grid_binning_hole_fill #(
    parameter int GRID_DIM = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x[31:0], pos_z[63:32], height[95:64], query_row[103:96], query_col[111:104]
    input  wire [111:0] s_axis_tdata,
    // cmd
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // cell_height[31:0], status[33:32], ring_distance[41:34], zero fill
    output logic [47:0] m_axis_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hgbhf_pkg::*;

    localparam int IDX_W = $clog2(GRID_DIM);

    logic [4:0]  shift_reg;
    logic        q_valid, q_ready, clearing;
    job_t        q_job;
    logic [31:0] h;
    logic [1:0]  s;
    logic [7:0]  d;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_CELL_SHIFT) ? {27'd0, shift_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shift_reg <= CELL_SHIFT_RST;
        else if (psel && penable && pwrite && paddr[2] == ADDR_CELL_SHIFT)
            shift_reg <= pwdata[4:0];
    end

    hgbhf_front #(.GRID_DIM(GRID_DIM)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cell_shift  (shift_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (s_axis_tuser),
        .in_pos_x    (s_axis_tdata[31:0]),
        .in_pos_z    (s_axis_tdata[63:32]),
        .in_height   (s_axis_tdata[95:64]),
        .in_query_row(s_axis_tdata[103:96]),
        .in_query_col(s_axis_tdata[111:104]),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_job       (q_job)
    );

    hgbhf_back #(.GRID_DIM(GRID_DIM), .IDX_W(IDX_W)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_job            (q_job),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_cell_height  (h),
        .out_status       (s),
        .out_ring_distance(d),
        .clearing         (clearing)
    );

    assign m_axis_tdata = {6'd0, d, s, h};

    property p_quiet_in_clear;
        @(posedge clk) disable iff (!rst_n) clearing |-> !m_axis_tvalid || $past(m_axis_tvalid);
    endproperty
    assert property (p_quiet_in_clear) else $error("result during clear");

    property p_shift_write;
        @(posedge clk) disable iff (!rst_n)
            (psel && penable && pwrite && paddr[2] == ADDR_CELL_SHIFT) |=> shift_reg == $past(pwdata[4:0]);
    endproperty
    assert property (p_shift_write) else $error("shift write lost");

    property p_ready_high;
        @(posedge clk) pready;
    endproperty
    assert property (p_ready_high) else $error("pready low");

endmodule
`default_nettype wire
